/* hdl/slm_pkg.sv */
// Shared types and constants for the smooth L1 mean loss block.
`default_nettype none
package slm_pkg;

  localparam int unsigned MAX_ELEMENTS_DEF = 65536;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned BETA_W = 31;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned QDEPTH = 2;

  localparam logic OP_FWD = 1'b0;
  localparam logic OP_GRAD = 1'b1;
  localparam logic KIND_MEAN = 1'b0;
  localparam logic KIND_GRAD = 1'b1;

  typedef struct packed {
    logic opcode;
    logic signed [DATA_W-1:0] prediction;
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] upstream_grad;
    logic last;
  } in_t;

  typedef struct packed {
    logic kind;
    logic signed [DATA_W-1:0] value;
    logic saturated;
  } out_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic op;
    logic last;
    logic quad;
    logic neg;
    logic [DATA_W-1:0] ad;
    logic [DATA_W-1:0] ag;
  } entry_t;

endpackage
`default_nettype wire

/* hdl/slm_front.sv */
// Front end: takes an item apart into magnitudes, signs and the Huber region.
`default_nettype none
module slm_front (
  input  wire slm_pkg::in_t in_data,
  input  wire [slm_pkg::BETA_W-1:0] beta_eff,
  output slm_pkg::entry_t entry
);
  import slm_pkg::*;

  logic signed [DATA_W:0] d;
  logic [DATA_W:0] ad_full;
  logic [DATA_W:0] ag_full;
  logic g_neg;
  logic d_neg;
  logic d_zero;

  always_comb begin
    d = {in_data.prediction[DATA_W-1], in_data.prediction}
      - {in_data.target[DATA_W-1], in_data.target};
    d_neg = d[DATA_W];
    d_zero = (d == '0);
    ad_full = d_neg ? (~d + 1'b1) : d;
    g_neg = in_data.upstream_grad[DATA_W-1];
    ag_full = g_neg ? (~{1'b1, in_data.upstream_grad} + 1'b1)
                    : {1'b0, in_data.upstream_grad};
    entry.op = in_data.opcode;
    entry.last = in_data.last;
    entry.ad = ad_full[DATA_W-1:0];
    entry.ag = ag_full[DATA_W-1:0];
    entry.quad = (ad_full[DATA_W-1:0] < {1'b0, beta_eff});
    // Outside the quadratic region a zero difference counts as negative.
    entry.neg = entry.quad ? (g_neg != d_neg) : (g_neg != (d_neg | d_zero));
  end

endmodule
`default_nettype wire

/* hdl/slm_fifo.sv */
// Short queue between the front end and the sequencer.
`default_nettype none
module slm_fifo (
  input  wire clk,
  input  wire rst,
  input  wire push,
  input  wire slm_pkg::entry_t wdata,
  input  wire pop,
  output logic full,
  output logic empty,
  output slm_pkg::entry_t head
);
  import slm_pkg::*;

  localparam int unsigned PTR_W = $clog2(QDEPTH);

  entry_t mem [QDEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0] fill;
  logic do_push;
  logic do_pop;

  assign full = (fill == QDEPTH[PTR_W:0]);
  assign empty = (fill == '0);
  assign head = mem[rptr];
  assign do_push = push & ~full;
  assign do_pop = pop & ~empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      fill <= fill + {{PTR_W{1'b0}}, do_push} - {{PTR_W{1'b0}}, do_pop};
    end
  end

endmodule
`default_nettype wire

/* hdl/slm_back.sv */
// Back end: sequencer with a shared multiplier and a bit-serial divider.
`default_nettype none
module slm_back #(
  parameter int unsigned MAX_ELEMENTS = slm_pkg::MAX_ELEMENTS_DEF
) (
  input  wire clk,
  input  wire rst,
  input  wire [slm_pkg::BETA_W-1:0] beta_eff,
  input  wire q_empty,
  input  wire slm_pkg::entry_t q_head,
  output logic q_pop,
  output logic out_valid,
  input  wire out_stall,
  output slm_pkg::out_t out_data
);
  import slm_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned W = 64;
  localparam logic [W-1:0] POS_MAX = 64'h0000_0000_7FFF_FFFF;
  localparam logic [W-1:0] NEG_MAX = 64'h0000_0000_8000_0000;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_MUL2 = 7'b0000100,
    S_PREP = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_ACC  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;
  entry_t ent;
  logic [W-1:0] prod;
  logic [W-1:0] prod2;
  logic [W-1:0] quo;
  logic [W-1:0] rem;
  logic [W-1:0] dvs;
  logic [5:0] dcnt;
  logic div_term;
  logic ovf_hold;
  logic [W-1:0] loss_sum;
  logic [CNT_W-1:0] element_count;
  logic [CNT_W-1:0] pass_count;
  logic overflow_seen;

  logic [DATA_W-1:0] mul_a;
  logic [DATA_W-1:0] mul_b;
  logic [W-1:0] mul_p;
  logic [W:0] rem_sh;
  logic rem_ge;
  logic [W:0] rem_sub;
  logic [DATA_W+1:0] lin;
  logic [W-1:0] term;
  logic [W-1:0] sum_new;
  logic [CNT_W-1:0] cnt_new;
  logic ovf_new;
  logic [CNT_W-1:0] n_mean;
  logic neg_eff;
  logic out_free;
  logic out_load;
  out_t res;

  assign out_free = ~out_valid | ~out_stall;
  assign out_load = (state == S_OUT) & out_free;
  assign q_pop = (state == S_IDLE) & ~q_empty;

  always_comb begin
    mul_a = (state == S_MUL2) ? DATA_W'(pass_count)
          : ((ent.op == OP_GRAD) ? ent.ag : ent.ad);
    mul_b = (state == S_MUL2) ? DATA_W'(beta_eff) : ent.ad;
    mul_p = mul_a * mul_b;
  end

  // One quotient bit per cycle, restoring form.
  always_comb begin
    rem_sh = {rem, quo[W-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    rem_ge = ~rem_sub[W];
  end

  always_comb begin
    lin = ({1'b0, ent.ad, 1'b0} - {3'b000, beta_eff} + 1'b1) >> 1;
    term = ent.quad ? quo : W'(lin);
    if (element_count >= CNT_W'(MAX_ELEMENTS)) begin
      sum_new = loss_sum;
      cnt_new = element_count;
      ovf_new = 1'b1;
    end else begin
      sum_new = loss_sum + term;
      cnt_new = element_count + 1'b1;
      ovf_new = overflow_seen;
    end
    n_mean = (cnt_new == '0) ? CNT_W'(1) : cnt_new;
  end

  always_comb begin
    res.kind = ent.op;
    res.saturated = 1'b0;
    res.value = '0;
    neg_eff = ent.neg & (quo != '0);
    if (ent.op == OP_FWD) begin
      res.kind = KIND_MEAN;
      res.saturated = ovf_hold;
      if (quo > POS_MAX) begin
        res.value = POS_MAX[DATA_W-1:0];
        res.saturated = 1'b1;
      end else begin
        res.value = quo[DATA_W-1:0];
      end
    end else begin
      res.kind = KIND_GRAD;
      if (neg_eff) begin
        if (quo > NEG_MAX) begin
          res.value = NEG_MAX[DATA_W-1:0];
          res.saturated = 1'b1;
        end else begin
          res.value = ~quo[DATA_W-1:0] + 1'b1;
        end
      end else if (quo > POS_MAX) begin
        res.value = POS_MAX[DATA_W-1:0];
        res.saturated = 1'b1;
      end else begin
        res.value = quo[DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      loss_sum <= '0;
      element_count <= '0;
      pass_count <= '0;
      overflow_seen <= 1'b0;
      ovf_hold <= 1'b0;
      div_term <= 1'b0;
      dcnt <= '0;
    end else begin
      out_valid <= out_load | (out_valid & out_stall);
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            ent <= q_head;
            rem <= '0;
            dcnt <= '0;
            div_term <= 1'b0;
            if (q_head.op == OP_FWD) begin
              div_term <= 1'b1;
              state <= q_head.quad ? S_MUL : S_ACC;
            end else if (pass_count == '0) begin
              quo <= '0;
              state <= S_OUT;
            end else if (q_head.quad) begin
              state <= S_MUL;
            end else begin
              quo <= W'(q_head.ag) + W'(pass_count >> 1);
              dvs <= W'(pass_count);
              state <= S_DIV;
            end
          end
        end
        S_MUL: begin
          prod <= mul_p;
          state <= (ent.op == OP_FWD) ? S_PREP : S_MUL2;
        end
        S_MUL2: begin
          prod2 <= mul_p;
          state <= S_PREP;
        end
        S_PREP: begin
          if (ent.op == OP_FWD) begin
            quo <= prod + W'(beta_eff);
            dvs <= W'(beta_eff) << 1;
          end else begin
            quo <= prod + (prod2 >> 1);
            dvs <= prod2;
          end
          rem <= '0;
          dcnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
          quo <= {quo[W-2:0], rem_ge};
          dcnt <= dcnt + 1'b1;
          if (dcnt == 6'd63) begin
            state <= div_term ? S_ACC : S_OUT;
          end
        end
        S_ACC: begin
          if (ent.last) begin
            // Close the pass and start the mean division.
            quo <= sum_new + W'(n_mean >> 1);
            dvs <= W'(n_mean);
            rem <= '0;
            dcnt <= '0;
            div_term <= 1'b0;
            ovf_hold <= ovf_new;
            pass_count <= cnt_new;
            loss_sum <= '0;
            element_count <= '0;
            overflow_seen <= 1'b0;
            state <= S_DIV;
          end else begin
            loss_sum <= sum_new;
            element_count <= cnt_new;
            overflow_seen <= ovf_new;
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

/* hdl/smooth_l1_loss_mean.sv */
// Smooth L1 loss with mean reduction and per-element gradient, top level.
//
// Items enter on in_valid/in_stall with an in_t payload; a transfer happens
// when in_valid is high and in_stall is low. Results leave on
// out_valid/out_stall with an out_t payload. The beta register is written
// through cfg_we/cfg_wdata; the user must write it only while the block is
// idle, which the block does not enforce; a beta of zero acts as one LSB. A
// two-entry queue decouples the front end from the sequencer, which handles
// one item at a time: a forward element is accumulated at once in the linear
// region and after multiply, prep and divide in the quadratic one; a closing
// element adds the mean division and the output load. A gradient runs divide
// and output (two multiplies and prep first when quadratic), or only output
// before any pass has closed. The shared bit-serial divider makes one quotient
// bit per cycle over 64 bits. Synchronous reset clears the sum, counts, queue
// and output and sets beta to 1.0. A stalled result holds in the output
// register; the sequencer waits, and the queue fills before in_stall rises.
`default_nettype none
module smooth_l1_loss_mean #(
  parameter int unsigned MAX_ELEMENTS = slm_pkg::MAX_ELEMENTS_DEF,
  parameter int unsigned FRAC_BITS = slm_pkg::FRAC_BITS_DEF
) (
  input  wire clk,
  input  wire rst,
  input  wire in_valid,
  output logic in_stall,
  input  wire slm_pkg::in_t in_data,
  output logic out_valid,
  input  wire out_stall,
  output slm_pkg::out_t out_data,
  input  wire cfg_we,
  input  wire [slm_pkg::BETA_W-1:0] cfg_wdata
);
  import slm_pkg::*;

  logic [BETA_W-1:0] beta;
  logic [BETA_W-1:0] beta_eff;
  entry_t fe_entry;
  entry_t q_head;
  logic q_full;
  logic q_empty;
  logic q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta <= BETA_W'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      beta <= cfg_wdata;
    end
  end

  assign beta_eff = (beta == '0) ? BETA_W'(1) : beta;
  assign in_stall = q_full;

  slm_front u_front (
    .in_data  (in_data),
    .beta_eff (beta_eff),
    .entry    (fe_entry)
  );

  slm_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (in_valid),
    .wdata (fe_entry),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  slm_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .beta_eff  (beta_eff),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* sim/smooth_l1_loss_mean_tb.sv */
// Testbench for the smooth L1 mean loss block: directed and random items against a predictor.
`timescale 1ns / 1ps
module smooth_l1_loss_mean_tb;
  import slm_pkg::*;

  localparam int unsigned STALL_LIMIT = 6000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [BETA_W-1:0] cfg_wdata = '0;

  // Predictor state.
  logic [63:0] fwd_sum;
  logic [31:0] fwd_count;
  logic [31:0] kept_count;
  logic dropped;
  logic [BETA_W-1:0] beta_reg;

  out_t pending_results[$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_checked = 0;
  int unsigned means_checked = 0;
  int unsigned sat_checked = 0;
  bit idle_en = 1'b0;
  int unsigned hold_reqs = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  smooth_l1_loss_mean uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] clamp_signed(input logic neg, input logic [63:0] mag,
                                               inout logic sat);
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        mag = 64'h8000_0000;
        sat = 1'b1;
      end
      return 32'(64'd0 - mag);
    end
    if (mag > 64'h7FFF_FFFF) begin
      mag = 64'h7FFF_FFFF;
      sat = 1'b1;
    end
    return mag[31:0];
  endfunction

  // Advances the predictor by one item; returns 1 when the item yields a result.
  function automatic logic loss_grad_predict(input in_t it, output out_t res);
    logic [63:0] b, ad, ag, term, n, mean, num, den, mag;
    logic signed [63:0] d, g;
    logic neg, sat;
    b = (beta_reg == 0) ? 64'd1 : 64'(beta_reg);
    d = $signed(it.prediction);
    d = d - $signed(it.target);
    ad = (d < 0) ? 64'(-d) : 64'(d);
    sat = 1'b0;
    res = '0;
    if (it.opcode == OP_FWD) begin
      if (ad < b) term = (ad * ad + b) / (2 * b);
      else term = (2 * ad - b + 1) >> 1;
      if (fwd_count >= MAX_ELEMENTS_DEF) begin
        dropped = 1'b1;
      end else begin
        fwd_sum = fwd_sum + term;
        fwd_count = fwd_count + 1;
      end
      if (!it.last) return 1'b0;
      n = (fwd_count == 0) ? 64'd1 : 64'(fwd_count);
      mean = (fwd_sum + n / 2) / n;
      sat = dropped;
      if (mean > 64'h7FFF_FFFF) begin
        mean = 64'h7FFF_FFFF;
        sat = 1'b1;
      end
      res.kind = KIND_MEAN;
      res.value = mean[31:0];
      res.saturated = sat;
      kept_count = fwd_count;
      fwd_sum = '0;
      fwd_count = '0;
      dropped = 1'b0;
      return 1'b1;
    end
    res.kind = KIND_GRAD;
    if (kept_count == 0) return 1'b1;
    g = $signed(it.upstream_grad);
    ag = (g < 0) ? 64'(-g) : 64'(g);
    n = 64'(kept_count);
    if (ad < b) begin
      num = ag * ad;
      den = n * b;
      neg = (g < 0) != (d < 0);
    end else begin
      num = ag;
      den = n;
      neg = (g < 0) != (d <= 0);
    end
    mag = (num + den / 2) / den;
    if (mag == 0) neg = 1'b0;
    res.value = clamp_signed(neg, mag, sat);
    res.saturated = sat;
    return 1'b1;
  endfunction

  task automatic send_item(input in_t it);
    out_t res;
    int unsigned gap;
    gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (loss_grad_predict(it, res)) pending_results.push_back(res);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Waits for every expected result, then lets the block finish silent work.
  task automatic drain();
    release_input();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_beta(input logic [BETA_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    beta_reg = v;
  endtask

  function automatic in_t make_item(input logic op, input logic [31:0] p, input logic [31:0] t,
                                    input logic [31:0] g, input logic lst);
    in_t it;
    it.opcode = op;
    it.prediction = p;
    it.target = t;
    it.upstream_grad = g;
    it.last = lst;
    return it;
  endfunction

  // Picks a pair whose difference lands near beta, small, anywhere, or at the range extremes.
  task automatic pick_pair(output logic [31:0] p, output logic [31:0] t);
    logic [31:0] off;
    p = $urandom;
    case ($urandom_range(0, 3))
      0: t = $urandom;
      1: begin
        off = $urandom_range(0, 2 * (beta_reg == 0 ? 1 : int'(beta_reg > 32'h3FFF_FFFF ?
              32'h3FFF_FFFF : beta_reg)));
        t = $urandom_range(0, 1) ? p - off : p + off;
      end
      2: t = p + $urandom_range(0, 7) - 3;
      default: begin
        p = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        t = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
    endcase
  endtask

  task automatic random_pass(input int unsigned len, input int unsigned grads);
    logic [31:0] p, t;
    for (int unsigned i = 0; i < len; i++) begin
      pick_pair(p, t);
      send_item(make_item(OP_FWD, p, t, $urandom, i == len - 1));
    end
    for (int unsigned i = 0; i < grads; i++) begin
      pick_pair(p, t);
      send_item(make_item(OP_GRAD, p, t, $urandom, 1'($urandom_range(0, 1))));
    end
  endtask

  task automatic test_gradient_before_pass();
    send_item(make_item(OP_GRAD, 32'h0001_0000, 32'h0, 32'h7FFF_FFFF, 1'b0));
    send_item(make_item(OP_GRAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
  endtask

  task automatic test_directed_extremes();
    // Huge differences against beta of one bring the mean just under the clamp.
    send_item(make_item(OP_FWD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0));
    send_item(make_item(OP_FWD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0));
    send_item(make_item(OP_FWD, 32'h0000_8000, 32'h0, 32'h0, 1'b0));
    send_item(make_item(OP_FWD, 32'h1234_5678, 32'h1234_5678, 32'h0, 1'b1));
    send_item(make_item(OP_GRAD, 32'h0, 32'h0, 32'h0001_0000, 1'b0));
    send_item(make_item(OP_GRAD, 32'h0, 32'h0000_4000, 32'h8000_0000, 1'b0));
    send_item(make_item(OP_GRAD, 32'h0003_0000, 32'h0, 32'h8000_0000, 1'b0));
    send_item(make_item(OP_GRAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    send_item(make_item(OP_FWD, 32'h0000_0001, 32'h0, 32'h0, 1'b1));
    send_item(make_item(OP_GRAD, 32'h0000_0001, 32'h0, 32'hFFFF_FFFF, 1'b0));
    write_beta(31'd1);
    send_item(make_item(OP_FWD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1));
    send_item(make_item(OP_GRAD, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 1'b0));
    send_item(make_item(OP_GRAD, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    send_item(make_item(OP_GRAD, 32'h0, 32'h0, 32'h8000_0000, 1'b0));
    write_beta(31'h7FFF_FFFF);
    send_item(make_item(OP_FWD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1));
    send_item(make_item(OP_GRAD, 32'h4000_0000, 32'h0, 32'h8000_0000, 1'b0));
    send_item(make_item(OP_GRAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    write_beta(31'd0);
    send_item(make_item(OP_FWD, 32'h0, 32'h0, 32'h0, 1'b1));
    send_item(make_item(OP_GRAD, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0));
  endtask

  task automatic test_random_phases();
    logic [BETA_W-1:0] betas[6];
    betas[0] = 31'h0001_0000;
    betas[1] = 31'd1;
    betas[2] = 31'h7FFF_FFFF;
    betas[3] = 31'(($urandom & 32'h00FF_FFFF) | 1);
    betas[4] = 31'($urandom);
    betas[5] = 31'h0000_0100;
    foreach (betas[k]) begin
      write_beta(betas[k]);
      while (items_sent < 150 * (k + 1) + 40) begin
        if ($urandom_range(0, 9) == 0) begin
          // Stray items: one to three gradients outside any forward pass.
          random_pass(0, $urandom_range(1, 3));
        end else begin
          random_pass($urandom_range(1, 12), $urandom_range(0, 6));
        end
      end
    end
  endtask

  task automatic test_output_hold();
    logic [31:0] p, t;
    write_beta(31'h0001_0000);
    send_item(make_item(OP_FWD, 32'h0000_4000, 32'h0, 32'h0, 1'b1));
    hold_reqs++;
    for (int i = 0; i < 12; i++) begin
      pick_pair(p, t);
      send_item(make_item(OP_GRAD, p, t, $urandom, 1'b0));
    end
  endtask

  task automatic test_quiet_tail();
    idle_en = 1'b0;
    write_beta(31'($urandom_range(1, 32'h0004_0000)));
    repeat (20) random_pass($urandom_range(1, 8), $urandom_range(0, 4));
  endtask

  // Result side: random stall bursts plus one long requested hold.
  always @(negedge clk) begin
    if (hold_reqs != hold_done) begin
      hold_done++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0b value=%h sat=%0b", $time,
                 out_data.kind, out_data.value, out_data.saturated);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.kind == KIND_MEAN) means_checked++;
        if (want.saturated) sat_checked++;
        if (out_data.kind !== want.kind) begin
          errors++;
          $display("%0t: kind expected %0b actual %0b", $time, want.kind, out_data.kind);
        end
        if (out_data.value !== want.value) begin
          errors++;
          $display("%0t: value expected %h actual %h", $time, want.value, out_data.value);
        end
        if (out_data.saturated !== want.saturated) begin
          errors++;
          $display("%0t: saturated expected %0b actual %0b", $time, want.saturated,
                   out_data.saturated);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    fwd_sum = '0;
    fwd_count = '0;
    kept_count = '0;
    dropped = 1'b0;
    beta_reg = 31'h0001_0000;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    idle_en = 1'b1;
    test_gradient_before_pass();
    test_directed_extremes();
    test_random_phases();
    test_output_hold();
    test_quiet_tail();
    drain();
    $display("Covered %0d items and %0d results (%0d means, %0d clamped),", items_sent,
             results_checked, means_checked, sat_checked);
    $display("including beta extremes, output hold-off and a tail without idling.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
